@@ rtl/eldf_pkg.sv @@
`timescale 1ns / 1ps
// types and constants shared by the escaped length frame deframer
package eldf_pkg;

    localparam int BYTE_W  = 8;
    localparam int POS_W   = 10;
    localparam int COUNT_W = 17;

    localparam logic [BYTE_W-1:0]  MARK_START  = 8'hFD;
    localparam logic [BYTE_W-1:0]  MARK_ESCAPE = 8'hFC;
    localparam logic [BYTE_W-1:0]  HIGH_BIT    = 8'h80;
    localparam logic [COUNT_W-1:0] CRC_BYTES   = 17'd2;

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_DATA
    } phase_t;

endpackage

@@ rtl/eldf_if.sv @@
`timescale 1ns / 1ps
// channel interfaces of the escaped length frame deframer

interface eldf_cfg_if;
    logic valid;
    logic ready;
    logic decode_escaped;

    modport source (output valid, output decode_escaped, input ready);
    modport sink (input valid, input decode_escaped, output ready);
endinterface

interface eldf_in_if
    import eldf_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              command;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink (input valid, input command, input data_byte, output ready);
endinterface

interface eldf_out_if
    import eldf_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] stored_byte;
    logic [POS_W-1:0]  position;
    logic              frame_end;
    logic              buffer_full;

    modport source (
        output valid, output stored_byte, output position,
        output frame_end, output buffer_full, input ready
    );
    modport sink (
        input valid, input stored_byte, input position,
        input frame_end, input buffer_full, output ready
    );
endinterface

@@ rtl/escaped_length_frame_deframer.sv @@
`timescale 1ns / 1ps
// escaped length frame deframer top level
//
//  channel   dir  payload                                          transfer
//  cfg       in   decode_escaped                                   valid & ready
//  item      in   command, data_byte                               valid & ready
//  result    out  stored_byte, position, frame_end, buffer_full    valid & ready
//
//  input register, one pass of parse logic, result register
//  one byte per cycle unless a waiting result is not taken; result valid is registered
//  a byte that stores nothing (flush, decoded escape, idle data) yields no result
//  item.ready drops only while the input register holds a byte and a result waits
//  rst_n clears parser state and sets decode_escaped; cfg.ready is always high

module escaped_length_frame_deframer
    import eldf_pkg::*;
#(
    parameter int BUFFER_BYTES = 1024
)
(
    input  logic     clk,
    input  logic     rst_n,
    eldf_cfg_if.sink cfg,
    eldf_in_if.sink  item,
    eldf_out_if.source result
);

    localparam int FILL_W = $clog2(BUFFER_BYTES);
    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(BUFFER_BYTES - 1);

    logic              decode_reg;

    logic              in_valid_reg;
    logic              in_cmd_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    phase_t             phase_reg, phase_next;
    logic               esc_reg, esc_next;
    logic [COUNT_W-1:0] len_reg, len_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [POS_W-1:0]  out_pos_reg;
    logic              out_end_reg;
    logic              out_full_reg;

    logic               advance;
    logic               store;
    logic               done;
    logic               full;
    logic [BYTE_W-1:0]  byte_out;
    logic [FILL_W-1:0]  pos;

    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;
    assign cfg.ready  = 1'b1;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decode_reg <= 1'b1;
        end
        else if (cfg.valid)
        begin
            decode_reg <= cfg.decode_escaped;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_cmd_reg  <= item.command;
            in_byte_reg <= item.data_byte;
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            esc_reg   <= 1'b0;
            len_reg   <= '0;
            cnt_reg   <= '0;
            fill_reg  <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            fill_reg  <= fill_next;
        end
    end

    always_comb
    begin
        logic [BYTE_W-1:0]  len_byte;
        logic [COUNT_W-1:0] cnt_inc;

        phase_next = phase_reg;
        esc_next   = esc_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        fill_next  = fill_reg;
        store      = 1'b0;
        done       = 1'b0;
        full       = 1'b0;
        byte_out   = in_byte_reg;
        pos        = fill_reg;
        len_byte   = esc_reg ? (in_byte_reg | HIGH_BIT) : in_byte_reg;
        cnt_inc    = cnt_reg + COUNT_W'(1);

        if (in_cmd_reg == CMD_FLUSH)
        begin
            phase_next = PH_IDLE;
            fill_next  = '0;
            esc_next   = 1'b0;
        end
        else if (in_byte_reg == MARK_START)
        begin
            pos        = '0;
            esc_next   = 1'b0;
            phase_next = PH_LEN_HI;
            store      = 1'b1;
        end
        else if (in_byte_reg == MARK_ESCAPE)
        begin
            esc_next = 1'b1;
            store    = !decode_reg;
        end
        else
        begin
            if (esc_reg && decode_reg)
            begin
                byte_out = in_byte_reg | HIGH_BIT;
            end
            unique case (phase_reg)
                PH_IDLE:
                begin
                    store = 1'b0;
                end
                PH_LEN_HI:
                begin
                    len_next   = {1'b0, len_byte, 8'h00};
                    phase_next = PH_LEN_LO;
                    store      = 1'b1;
                end
                PH_LEN_LO:
                begin
                    len_next   = (len_reg | COUNT_W'(len_byte)) + CRC_BYTES;
                    cnt_next   = '0;
                    phase_next = PH_DATA;
                    store      = 1'b1;
                end
                PH_DATA:
                begin
                    cnt_next = cnt_inc;
                    done     = (cnt_inc == len_reg);
                    store    = 1'b1;
                end
                default:
                begin
                    store = 1'b0;
                end
            endcase
            if (phase_reg != PH_IDLE)
            begin
                esc_next = 1'b0;
            end
        end

        if (store)
        begin
            full      = (pos == FILL_LAST);
            fill_next = full ? '0 : pos + FILL_W'(1);
            if (full || done)
            begin
                done       = 1'b1;
                phase_next = PH_IDLE;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= store;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && store)
        begin
            out_byte_reg <= byte_out;
            out_pos_reg  <= POS_W'(pos);
            out_end_reg  <= done;
            out_full_reg <= full;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.stored_byte = out_byte_reg;
    assign result.position    = out_pos_reg;
    assign result.frame_end   = out_end_reg;
    assign result.buffer_full = out_full_reg;

    // a forced hand-off always closes the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (!result.buffer_full || result.frame_end))
        else $error("buffer_full without frame_end");

    // a forced hand-off happens only at the last buffer slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.buffer_full) |-> (result.position == POS_W'(FILL_LAST)))
        else $error("buffer_full away from last slot");

    // a held input byte is never dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("input register lost a byte");

    // a start mark always restarts the buffer at slot zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && store && in_cmd_reg == CMD_APPEND && in_byte_reg == MARK_START)
        |=> (result.valid && result.position == '0 && phase_reg == PH_LEN_HI))
        else $error("start mark not at slot zero");

endmodule
